FILE: rtl/core/ss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring search package
// Shared widths, register indexes, defaults and types of the streaming
// substring search block.
// ----------------------------------------------------------------------------
package ss_pkg;

   localparam int PATTERN_MAX_DEF   = 16;
   localparam int POSITION_BITS_DEF = 16;

   localparam int BYTE_W        = 8;
   localparam int PAT_REG_BYTES = 16;
   localparam int LEN_REG_W     = 5;
   localparam int POS_OUT_W     = 16;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LEN  = 2'd2;

   localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctrl_type;

endpackage : ss_pkg
`default_nettype wire

FILE: rtl/core/ss_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring search channels
// Valid/ready channels for text bytes and for search results.
// ----------------------------------------------------------------------------
interface ss_req_if;
   logic             valid;
   logic             ready;
   ss_pkg::byte_type text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface : ss_req_if

interface ss_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [ss_pkg::POS_OUT_W-1:0] match_position;
   logic                         text_too_long;

   modport source (output valid, output found, output match_position,
                   output text_too_long, input ready);
   modport sink   (input valid, input found, input match_position,
                   input text_too_long, output ready);
endinterface : ss_rsp_if
`default_nettype wire

FILE: rtl/core/substring_search.sv
`timescale 1ns / 1ps
`default_nettype none
// One text byte per cycle unless a result waits; no bubbles between texts.
// Latency: the result is valid in the cycle after the terminator transfer.
// The compare is done combinationally by a row of PATTERN_MAX cells.
// Reset (synchronous) clears the pattern registers, the window, the counter
// and the pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Streaming substring search
// Scans text bytes against a configured pattern and reports the first match
// offset when the terminating zero byte arrives.
// ----------------------------------------------------------------------------
module substring_search #(
   parameter int PATTERN_MAX   = ss_pkg::PATTERN_MAX_DEF,
   parameter int POSITION_BITS = ss_pkg::POSITION_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ss_req_if.sink                              req_chan,
   ss_rsp_if.source                            rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [ss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ss_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ss_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int CMP_W = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
   localparam int POS_W = POSITION_BITS;

   logic [CSR_DATA_W-1:0] pat_low_ff, pat_high_ff;
   logic [LEN_REG_W-1:0]  pat_len_ff;

   logic [POS_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] first_ff, first_in;
   logic             seen_ff, seen_in;
   logic             ovf_ff, ovf_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 found_ff;
   logic [POS_OUT_W-1:0] pos_ff;
   logic                 too_long_ff;

   byte_type     pattern [PATTERN_MAX];
   logic [LEN_W-1:0] len_clamped, eff_len;
   logic [CMP_W-1:0] len_reg_x;
   win_ctrl_type win_ctrl;
   logic         accept, is_term, hit, at_max, record;
   logic [POS_W:0]   count_next;
   logic [POS_W+POS_OUT_W-1:0] first_wide;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAT_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PAT_HIGH: pat_high_ff <= csr_wdata;
            CSR_PAT_LEN:  pat_len_ff  <= csr_wdata[LEN_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pattern bytes beyond the register pair read as zero.
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pat
      if (i < PAT_REG_BYTES / 2) begin : g_low
         assign pattern[i] = pat_low_ff[i*BYTE_W +: BYTE_W];
      end else if (i < PAT_REG_BYTES) begin : g_high
         assign pattern[i] = pat_high_ff[(i - PAT_REG_BYTES / 2)*BYTE_W +: BYTE_W];
      end else begin : g_zero
         assign pattern[i] = TERMINATOR;
      end
   end

   // The pattern ends at its first zero byte or at the clamped length.
   assign len_reg_x   = CMP_W'(pat_len_ff);
   assign len_clamped = (len_reg_x > CMP_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                          : LEN_W'(len_reg_x);
   always_comb begin
      eff_len = len_clamped;
      for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
         if ((LEN_W'(k) < len_clamped) && (pattern[k] == TERMINATOR)) begin
            eff_len = LEN_W'(k);
         end
      end
   end

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept  = req_chan.valid && req_chan.ready;
   assign is_term = (req_chan.text_byte == TERMINATOR);

   assign win_ctrl.shift = accept && !is_term;
   assign win_ctrl.clear = accept && is_term;

   ss_window #(.PM(PATTERN_MAX), .LEN_W(LEN_W)) u_window (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (win_ctrl),
      .cur_byte (req_chan.text_byte),
      .pattern  (pattern),
      .eff_len  (eff_len),
      .hit      (hit)
   );

   assign at_max     = &count_ff;
   assign count_next = {1'b0, count_ff} + (POS_W+1)'(1);
   assign record     = (eff_len != '0) && !seen_ff && !ovf_ff && !at_max
                       && (count_next >= (POS_W+1)'(eff_len)) && hit;

   always_comb begin
      count_in = count_ff;
      first_in = first_ff;
      seen_in  = seen_ff;
      ovf_in   = ovf_ff;
      if (win_ctrl.clear) begin
         count_in = '0;
         first_in = '0;
         seen_in  = 1'b0;
         ovf_in   = 1'b0;
      end else if (win_ctrl.shift) begin
         if (at_max) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_next[POS_W-1:0];
            if (record) begin
               seen_in  = 1'b1;
               first_in = POS_W'(count_next - (POS_W+1)'(eff_len));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
         seen_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         first_ff <= first_in;
         seen_ff  <= seen_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Output register: holds the result until the sink takes the transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (win_ctrl.clear) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign first_wide = (POS_W+POS_OUT_W)'(first_ff);

   always_ff @(posedge clock) begin
      if (win_ctrl.clear) begin
         found_ff    <= (eff_len == '0) || seen_ff;
         pos_ff      <= ((eff_len == '0) || !seen_ff) ? '0 : first_wide[POS_OUT_W-1:0];
         too_long_ff <= ovf_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.found          = found_ff;
   assign rsp_chan.match_position = pos_ff;
   assign rsp_chan.text_too_long  = too_long_ff;

endmodule : substring_search
`default_nettype wire

FILE: rtl/core/ss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring search cell
// Holds one byte of the text window, passes it to its neighbor and compares
// its incoming byte with the pattern byte aligned to the pattern end.
// ----------------------------------------------------------------------------
module ss_cell #(
   parameter int PM    = ss_pkg::PATTERN_MAX_DEF,
   parameter int J     = 0,
   parameter int LEN_W = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ss_pkg::win_ctrl_type ctrl,
   input  wire ss_pkg::byte_type     in_byte,
   input  wire ss_pkg::byte_type     pattern [PM],
   input  wire logic [LEN_W-1:0]     eff_len,
   output ss_pkg::byte_type          hold_byte,
   output logic                      match_ok
);
   import ss_pkg::*;

   localparam int IDX_W = (PM > 1) ? $clog2(PM) : 1;
   localparam logic [LEN_W-1:0] J_L = LEN_W'(J);

   byte_type         hold_ff;
   byte_type         hold_in;
   logic [IDX_W-1:0] idx;

   always_comb begin
      if (ctrl.clear) begin
         hold_in = TERMINATOR;
      end else if (ctrl.shift) begin
         hold_in = in_byte;
      end else begin
         hold_in = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= TERMINATOR;
      end else begin
         hold_ff <= hold_in;
      end
   end

   // Window position J lines up with pattern byte eff_len-1-J.
   always_comb begin
      idx      = '0;
      match_ok = 1'b1;
      if (J_L < eff_len) begin
         idx      = IDX_W'(eff_len - LEN_W'(1) - J_L);
         match_ok = (in_byte == pattern[idx]);
      end
   end

   assign hold_byte = hold_ff;

endmodule : ss_cell
`default_nettype wire

FILE: rtl/core/ss_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring search window
// Row of cells: shifts the text window one byte per shift, clears it on clear,
// and tells whether the window ending at the current byte equals the pattern.
// ----------------------------------------------------------------------------
module ss_window #(
   parameter int PM    = ss_pkg::PATTERN_MAX_DEF,
   parameter int LEN_W = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ss_pkg::win_ctrl_type ctrl,
   input  wire ss_pkg::byte_type     cur_byte,
   input  wire ss_pkg::byte_type     pattern [PM],
   input  wire logic [LEN_W-1:0]     eff_len,
   output logic                      hit
);
   import ss_pkg::*;

   byte_type     chain [PM];
   logic [PM-1:0] ok;

   assign chain[0] = cur_byte;

   for (genvar j = 0; j < PM; j++) begin : g_cell
      if (j < PM - 1) begin : g_mid
         ss_cell #(.PM(PM), .J(j), .LEN_W(LEN_W)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .in_byte   (chain[j]),
            .pattern   (pattern),
            .eff_len   (eff_len),
            .hold_byte (chain[j+1]),
            .match_ok  (ok[j])
         );
      end else begin : g_last
         ss_cell #(.PM(PM), .J(j), .LEN_W(LEN_W)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .in_byte   (chain[j]),
            .pattern   (pattern),
            .eff_len   (eff_len),
            .hold_byte (),
            .match_ok  (ok[j])
         );
      end
   end

   assign hit = &ok;

endmodule : ss_window
`default_nettype wire
